[rtl/core/dicom_element_header_walker_assert.svh]
// Assertion macros used by the checker of the element header walker.
`ifndef DICOM_ELEMENT_HEADER_WALKER_ASSERT_SVH
`define DICOM_ELEMENT_HEADER_WALKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DEHW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DEHW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dehw_pkg.sv]
// Types, constants and helper functions of the element header walker.
`default_nettype none

package dehw_pkg;

  typedef enum logic [1:0] {
    PH_PREAMBLE,
    PH_HEADER,
    PH_SKIP,
    PH_TRAIL
  } phase_t;

  typedef enum logic [2:0] {
    RC_ELEMENT,
    RC_DONE,
    RC_MISSING_PREAMBLE,
    RC_TRUNC_LONG,
    RC_TRUNC_SHORT,
    RC_UNDEF_LENGTH,
    RC_OVERRUN
  } code_t;

  typedef struct packed {
    code_t       code;
    logic [15:0] group_number;
    logic [15:0] element_number;
    logic [7:0]  vr_first_char;
    logic [7:0]  vr_second_char;
    logic [31:0] value_length;
    logic [31:0] value_offset;
    logic        last_of_run;
  } result_t;

  localparam logic [31:0] MAGIC_WORD     = "DICM";
  localparam logic [31:0] MIN_FILE_LEN   = 32'd132;
  localparam logic [29:0] MARKER_WORD    = 30'd32;  // positions 128..131
  localparam logic [1:0]  MARKER_LAST    = 2'd3;
  localparam logic [31:0] UNDEF_LEN      = 32'hFFFF_FFFF;
  localparam logic [3:0]  HDR_BASE_BYTES = 4'd6;
  localparam logic [3:0]  HDR_SHORT_END  = 4'd8;
  localparam logic [3:0]  HDR_LONG_END   = 4'd12;
  localparam int          FIFO_DEPTH     = 4;
  localparam int          FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int          FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

  // Expected marker character for position 128 + idx.
  function automatic logic [7:0] marker_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = MAGIC_WORD[31:24];
      2'd1:    ch = MAGIC_WORD[23:16];
      2'd2:    ch = MAGIC_WORD[15:8];
      default: ch = MAGIC_WORD[7:0];
    endcase
    return ch;
  endfunction

  // VRs that carry two reserved bytes and a 4-byte length.
  function automatic logic vr_is_long(input logic [7:0] a, input logic [7:0] b);
    logic lng;
    case (a)
      "O":     lng = b inside {"B", "D", "F", "L", "V", "W"};
      "S":     lng = (b == "Q");
      "U":     lng = b inside {"C", "N", "R", "T"};
      default: lng = 1'b0;
    endcase
    return lng;
  endfunction

endpackage

`default_nettype wire

[rtl/core/dicom_element_header_walker.sv]
// Top level of the explicit-VR little-endian element header walker.
`default_nettype none

// Channel   Direction  Handshake                      Payload
// data      in         data_valid / data_ready        data_byte
// result    out        result_valid / result_ready    result_code .. last_of_run
// config    in         file_length_wr (no wait)       file_length
//
// Each byte is decoded in the cycle it is accepted, so one byte per cycle is
// sustained while data_ready stays high; its results are registered.
// A byte yields zero, one or two results, which are queued in a four-entry
// result FIFO; data_ready drops only while fewer than two FIFO slots are free.
// Reset is synchronous: the walk restarts at position zero, file_length is 1.
// Stalls on the result side back up into the FIFO and then into data_ready.
module dicom_element_header_walker
  import dehw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write
  input  wire logic        file_length_wr,
  input  wire logic [31:0] file_length,
  // Byte stream
  input  wire logic        data_valid,
  output logic             data_ready,
  input  wire logic [7:0]  data_byte,
  // Result stream
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [2:0]       result_code,
  output logic [15:0]      group_number,
  output logic [15:0]      element_number,
  output logic [7:0]       vr_first_char,
  output logic [7:0]       vr_second_char,
  output logic [31:0]      value_length,
  output logic [31:0]      value_offset,
  output logic             last_of_run
);

  // Walker state.
  logic [31:0] file_len;
  logic [31:0] pos;
  phase_t      phase;
  logic        marker_ok;
  logic [47:0] hdr;
  logic [3:0]  hdr_count;
  logic [31:0] skip;
  logic        walk_ended;

  phase_t      phase_next;
  logic        marker_ok_next;
  logic [47:0] hdr_next;
  logic [3:0]  hdr_count_next;
  logic [31:0] skip_next;
  logic        walk_ended_next;

  // Result FIFO.
  result_t                fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  wr_ptr_inc;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_CNT_W-1:0]  count;
  logic [FIFO_CNT_W-1:0]  count_next;

  logic accept;
  logic go;
  logic pop;

  // Byte decode.
  logic [32:0] pos1;
  logic        in_marker;
  logic        marker_last;
  logic        marker_good;
  logic        short_file;
  logic        no_room;
  logic [47:0] hdr_w;
  logic [31:0] skip_w;
  logic [3:0]  count_inc;
  logic        lng;
  logic        hdr_base_done;
  logic        hdr_end;
  logic        trunc_long;
  logic        trunc_short;
  logic        overrun;
  logic [31:0] skip_dec;

  // Result selection.
  logic    prim_valid;
  code_t   prim_code;
  logic    prim_ends;
  logic    done_hit;
  result_t prim_res;
  result_t done_res;
  result_t res_a;
  result_t res_b;
  logic    push_a;
  logic    push_b;
  logic [1:0] push_n;

  assign accept = data_valid && data_ready;
  assign go     = accept && !walk_ended;
  assign pop    = result_valid && result_ready;

  // The FIFO must be able to take the worst case of two results per byte.
  assign data_ready   = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign result_valid = (count != '0);

  // ---------------------------------------------------------------------
  // Byte decode: everything the byte contributes, before phase gating.
  // ---------------------------------------------------------------------
  assign pos1        = {1'b0, pos} + 33'd1;
  assign in_marker   = (pos[31:2] == MARKER_WORD);
  assign marker_last = in_marker && (pos[1:0] == MARKER_LAST);
  assign marker_good = marker_ok && (data_byte == marker_char(pos[1:0]));
  assign short_file  = (file_len < MIN_FILE_LEN);
  assign no_room     = (hdr_count == '0) && (({1'b0, pos} + 33'd6) > {1'b0, file_len});

  // Group, element and VR bytes land in byte lanes of the header word.
  always_comb begin
    hdr_w = (hdr_count == '0) ? '0 : hdr;
    for (int i = 0; i < 6; i++) begin
      if (hdr_count == 4'(i)) begin
        hdr_w[8*i +: 8] = hdr_w[8*i +: 8] | data_byte;
      end
    end
  end

  assign lng = vr_is_long(hdr_w[39:32], hdr_w[47:40]);

  // Length bytes follow the VR directly for short VRs and after two reserved
  // bytes for long VRs.
  always_comb begin
    skip_w = (hdr_count == '0) ? '0 : skip;
    for (int j = 0; j < 4; j++) begin
      if (lng && hdr_count == 4'(j + 8)) begin
        skip_w[8*j +: 8] = skip_w[8*j +: 8] | data_byte;
      end
      if (!lng && j < 2 && hdr_count == 4'(j + 6)) begin
        skip_w[8*j +: 8] = skip_w[8*j +: 8] | data_byte;
      end
    end
  end

  assign count_inc     = hdr_count + 4'd1;
  assign hdr_base_done = (count_inc == HDR_BASE_BYTES);
  assign hdr_end       = !hdr_base_done &&
                         (count_inc >= (lng ? HDR_LONG_END : HDR_SHORT_END));
  assign trunc_long    = lng && (({1'b0, pos} + 33'd7) > {1'b0, file_len});
  assign trunc_short   = !lng && (({1'b0, pos} + 33'd3) > {1'b0, file_len});
  assign overrun       = ({1'b0, pos1} + {2'b0, skip_w}) > {2'b0, file_len};
  assign skip_dec      = (skip != '0) ? skip - 32'd1 : skip;

  // ---------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------
  always_comb begin
    phase_next     = phase;
    marker_ok_next = marker_ok;
    hdr_next       = hdr;
    hdr_count_next = hdr_count;
    skip_next      = skip;
    if (go) begin
      case (phase)
        PH_PREAMBLE: begin
          if (!short_file && in_marker) begin
            marker_ok_next = marker_good;
            if (marker_last && marker_good) begin
              phase_next     = PH_HEADER;
              hdr_count_next = '0;
              hdr_next       = '0;
              skip_next      = '0;
            end
          end
        end
        PH_HEADER: begin
          if (no_room) begin
            phase_next = PH_TRAIL;
          end else begin
            hdr_next       = hdr_w;
            skip_next      = skip_w;
            hdr_count_next = count_inc;
            if (hdr_end) begin
              hdr_count_next = '0;
              // A nonzero length is skipped; an error ends the walk anyway.
              if (skip_w != '0 && skip_w != UNDEF_LEN && !overrun) begin
                phase_next = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          skip_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next     = PH_HEADER;
            hdr_count_next = '0;
          end
        end
        default: begin
          // Trailing bytes are ignored.
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Results of this byte.
  // ---------------------------------------------------------------------
  always_comb begin
    prim_valid = 1'b0;
    prim_code  = RC_ELEMENT;
    if (go) begin
      case (phase)
        PH_PREAMBLE: begin
          if (short_file || (marker_last && !marker_good)) begin
            prim_valid = 1'b1;
            prim_code  = RC_MISSING_PREAMBLE;
          end
        end
        PH_HEADER: begin
          if (!no_room) begin
            if (hdr_base_done && (trunc_long || trunc_short)) begin
              prim_valid = 1'b1;
              prim_code  = trunc_long ? RC_TRUNC_LONG : RC_TRUNC_SHORT;
            end else if (hdr_end) begin
              prim_valid = 1'b1;
              if (skip_w == UNDEF_LEN) begin
                prim_code = RC_UNDEF_LENGTH;
              end else if (overrun) begin
                prim_code = RC_OVERRUN;
              end else begin
                prim_code = RC_ELEMENT;
              end
            end
          end
        end
        default: begin
          prim_valid = 1'b0;
        end
      endcase
    end

    prim_ends = prim_valid && (prim_code != RC_ELEMENT);
    done_hit  = go && !prim_ends && (pos1 >= {1'b0, file_len});

    prim_res      = '0;
    prim_res.code = prim_code;
    if (prim_code != RC_MISSING_PREAMBLE) begin
      prim_res.group_number   = hdr_w[15:0];
      prim_res.element_number = hdr_w[31:16];
      prim_res.vr_first_char  = hdr_w[39:32];
      prim_res.vr_second_char = hdr_w[47:40];
    end
    if (prim_code == RC_ELEMENT || prim_code == RC_UNDEF_LENGTH ||
        prim_code == RC_OVERRUN) begin
      prim_res.value_length = skip_w;
      prim_res.value_offset = pos1[31:0];
    end
    prim_res.last_of_run = !done_hit;

    done_res             = '0;
    done_res.code        = RC_DONE;
    done_res.last_of_run = 1'b1;

    res_a  = prim_valid ? prim_res : done_res;
    res_b  = done_res;
    push_a = prim_valid || done_hit;
    push_b = prim_valid && done_hit;
    push_n = {1'b0, push_a} + {1'b0, push_b};
  end

  assign walk_ended_next = walk_ended || prim_ends || done_hit;

  // ---------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      file_len <= 32'd1;
    end else if (file_length_wr) begin
      file_len <= file_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      phase      <= PH_PREAMBLE;
      marker_ok  <= 1'b1;
      hdr        <= '0;
      hdr_count  <= '0;
      skip       <= '0;
      walk_ended <= 1'b0;
    end else begin
      if (accept) begin
        pos <= pos1[31:0];
      end
      phase      <= phase_next;
      marker_ok  <= marker_ok_next;
      hdr        <= hdr_next;
      hdr_count  <= hdr_count_next;
      skip       <= skip_next;
      walk_ended <= walk_ended_next;
    end
  end

  assign wr_ptr_inc = wr_ptr + FIFO_PTR_W'(1);
  assign count_next = count + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      fifo_q[wr_ptr] <= res_a;
    end
    if (push_b) begin
      fifo_q[wr_ptr_inc] <= res_b;
    end
  end

  // Head of the FIFO drives the result port.
  assign result_code    = fifo_q[rd_ptr].code;
  assign group_number   = fifo_q[rd_ptr].group_number;
  assign element_number = fifo_q[rd_ptr].element_number;
  assign vr_first_char  = fifo_q[rd_ptr].vr_first_char;
  assign vr_second_char = fifo_q[rd_ptr].vr_second_char;
  assign value_length   = fifo_q[rd_ptr].value_length;
  assign value_offset   = fifo_q[rd_ptr].value_offset;
  assign last_of_run    = fifo_q[rd_ptr].last_of_run;

endmodule

`default_nettype wire

[rtl/core/dehw_checker.sv]
// Port-level checker for the element header walker, with its bind.
`default_nettype none

`include "dicom_element_header_walker_assert.svh"

module dehw_checker
  import dehw_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [2:0]  result_code,
  input wire logic [15:0] group_number,
  input wire logic [15:0] element_number,
  input wire logic [7:0]  vr_first_char,
  input wire logic [7:0]  vr_second_char,
  input wire logic [31:0] value_length,
  input wire logic [31:0] value_offset,
  input wire logic        last_of_run
);

  logic terminal_seen;
  logic terminal_take;
  logic zero_fields;

  assign terminal_take = result_valid && result_ready && (result_code != RC_ELEMENT);
  assign zero_fields   = (group_number == '0) && (element_number == '0) &&
                         (vr_first_char == '0) && (vr_second_char == '0) &&
                         (value_length == '0) && (value_offset == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      terminal_seen <= 1'b0;
    end else if (terminal_take) begin
      terminal_seen <= 1'b1;
    end
  end

  `DEHW_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
                    result_valid && $stable(result_code) && $stable(value_offset),
                    "stalled result changed")
  `DEHW_ASSERT_SAME(a_terminal_last, result_valid && (result_code != RC_ELEMENT),
                    last_of_run, "terminal result without last_of_run")
  `DEHW_ASSERT_SAME(a_quiet_after_end, terminal_seen, !result_valid,
                    "result after the walk ended")
  `DEHW_ASSERT_SAME(a_status_zero,
                    result_valid && (result_code == RC_DONE ||
                                     result_code == RC_MISSING_PREAMBLE),
                    zero_fields, "status result with nonzero fields")

endmodule

bind dicom_element_header_walker dehw_checker u_dehw_checker (.*);

`default_nettype wire

[tb/sv/dicom_element_header_walker_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench that walks a generated file through the element header walker.
module dicom_element_header_walker_tb;
  import dehw_pkg::*;

  // Timing of the bench. The clock runs at 12 ns and reset is held at the start.
  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 3;

  // Each side draws a wait of up to MAX_WAIT per transaction, except in stretches of full speed.
  localparam int MAX_WAIT = 8;

  // Once this many bytes are in, the result side stops for a long stretch so that the
  // result FIFO fills and the walker has to drop data_ready.
  localparam int HOLD_AT_BYTES = 400;
  localparam int HOLD_CYCLES = 400;

  // Cycles without any transaction before the run is declared hung. The longest correct
  // quiet stretch is the hold above plus two full waits, so this is several times that.
  localparam int WATCHDOG_LIMIT = 4000;

  // Results are registered in the walker before they show up; settling time covers that before a
  // register write, and a drain at the end catches any stray result.
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 10;

  // File positions at which the length register is rewritten.
  localparam int PHASE_A_BYTES = 850;
  localparam int PHASE_B_BYTES = 1700;

  localparam int NUM_LONG_VRS = 11;
  localparam int NUM_SHORT_VRS = 16;
  localparam int NUM_IGNORED = 12;

  // The walk can end only once per reset, so each run picks one way to finish it.
  typedef enum int {
    END_CLEAN,
    END_TRAILING,
    END_TRUNC_LONG,
    END_TRUNC_SHORT,
    END_UNDEF,
    END_OVERRUN,
    END_SHRINK
  } walk_end_t;

  // Ports of the walker. Every input has a known value from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        file_length_wr = 1'b0;
  logic [31:0] file_length = '0;
  logic        data_valid = 1'b0;
  logic        data_ready;
  logic [7:0]  data_byte = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [2:0]  result_code;
  logic [15:0] group_number;
  logic [15:0] element_number;
  logic [7:0]  vr_first_char;
  logic [7:0]  vr_second_char;
  logic [31:0] value_length;
  logic [31:0] value_offset;
  logic        last_of_run;

  // File bytes waiting to be sent, and the position of the next byte to be generated.
  logic [7:0]  file_bytes[$];
  logic [31:0] gen_pos = '0;

  // Records the walker still owes, oldest first.
  result_t     walk_records_due[$];

  // Our own copy of the walker state, advanced once per accepted byte.
  logic [31:0] file_len_model = 32'd1;
  logic [31:0] walk_pos = '0;
  phase_t      walk_phase = PH_PREAMBLE;
  logic        marker_good = 1'b1;
  logic [47:0] hdr_word = '0;
  logic [3:0]  hdr_count = '0;
  logic [31:0] length_acc = '0;
  logic        walk_done = 1'b0;

  // Handshake bookkeeping shared between the clocked processes.
  logic        byte_taken = 1'b0;
  logic        result_taken = 1'b0;
  int          bytes_in = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  // Sender and receiver pacing.
  int          send_gap = 0;
  bit          send_burst = 1'b0;
  int          recv_gap = 0;
  bit          recv_burst = 1'b0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  dicom_element_header_walker dut (
    .clk            (clk),
    .rst            (rst),
    .file_length_wr (file_length_wr),
    .file_length    (file_length),
    .data_valid     (data_valid),
    .data_ready     (data_ready),
    .data_byte      (data_byte),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result_code    (result_code),
    .group_number   (group_number),
    .element_number (element_number),
    .vr_first_char  (vr_first_char),
    .vr_second_char (vr_second_char),
    .value_length   (value_length),
    .value_offset   (value_offset),
    .last_of_run    (last_of_run)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ------------------------------------------------------------------------------------
  // Value representations
  // ------------------------------------------------------------------------------------

  // The VRs whose header carries two reserved bytes and a 32-bit length.
  function automatic bit long_form_vr(input logic [7:0] a, input logic [7:0] b);
    case ({a, b})
      "OB", "OD", "OF", "OL", "OV", "OW", "SQ", "UC", "UN", "UR", "UT": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [15:0] long_vr_name(input int idx);
    case (idx)
      0:       return "OB";
      1:       return "OD";
      2:       return "OF";
      3:       return "OL";
      4:       return "OV";
      5:       return "OW";
      6:       return "SQ";
      7:       return "UC";
      8:       return "UN";
      9:       return "UR";
      default: return "UT";
    endcase
  endfunction

  // Common short VRs, plus a few that share a first letter with a long VR but are not one.
  function automatic logic [15:0] short_vr_name(input int idx);
    case (idx)
      0:       return "AE";
      1:       return "CS";
      2:       return "DA";
      3:       return "DS";
      4:       return "FD";
      5:       return "IS";
      6:       return "LO";
      7:       return "PN";
      8:       return "SH";
      9:       return "UI";
      10:      return "UL";
      11:      return "US";
      12:      return "SS";
      13:      return "OX";
      14:      return "SB";
      default: return "UA";
    endcase
  endfunction

  // Mostly real VRs, sometimes two random characters.
  function automatic logic [15:0] pick_vr();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return long_vr_name($urandom_range(0, NUM_LONG_VRS - 1));
    if (r < 8) return short_vr_name($urandom_range(0, NUM_SHORT_VRS - 1));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // ------------------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------------------

  function automatic result_t make_record(input code_t code, input logic [47:0] hdr,
                                          input logic [31:0] len, input logic [31:0] off);
    result_t r;
    r.code           = code;
    r.group_number   = hdr[15:0];
    r.element_number = hdr[31:16];
    r.vr_first_char  = hdr[39:32];
    r.vr_second_char = hdr[47:40];
    r.value_length   = len;
    r.value_offset   = off;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  // Advances the walk by one file byte and queues the records that the byte produces.
  // Sums are taken one or two bits wider so that nothing wraps near the top of the
  // 32-bit range.
  task automatic walk_byte(input logic [7:0] b);
    logic [32:0] pos_w;
    logic [32:0] fl_w;
    logic [32:0] off_w;
    logic [33:0] reach;
    int          cnt;
    bit          lng;
    result_t     recs [0:1];
    int          nrec;
    pos_w = {1'b0, walk_pos};
    fl_w  = {1'b0, file_len_model};
    nrec  = 0;
    if (!walk_done) begin
      case (walk_phase)
        PH_PREAMBLE: begin
          if (file_len_model < MIN_FILE_LEN) begin
            // The file cannot even hold the preamble and marker.
            recs[nrec] = make_record(RC_MISSING_PREAMBLE, '0, '0, '0);
            nrec++;
            walk_done = 1'b1;
          end else if (walk_pos >= 32'd128 && walk_pos <= 32'd131) begin
            if (b != MAGIC_WORD[(3 - int'(walk_pos[1:0])) * 8 +: 8]) marker_good = 1'b0;
            if (walk_pos == 32'd131) begin
              if (!marker_good) begin
                recs[nrec] = make_record(RC_MISSING_PREAMBLE, '0, '0, '0);
                nrec++;
                walk_done = 1'b1;
              end else begin
                walk_phase = PH_HEADER;
                hdr_count  = '0;
                hdr_word   = '0;
                length_acc = '0;
              end
            end
          end
        end
        PH_HEADER: begin
          if (hdr_count == 0 && pos_w + 33'd6 > fl_w) begin
            // Too few bytes left for a header: the rest of the file is ignored.
            walk_phase = PH_TRAIL;
          end else begin
            cnt = hdr_count;
            if (cnt == 0) begin
              hdr_word   = '0;
              length_acc = '0;
            end
            if (cnt < int'(HDR_BASE_BYTES)) begin
              hdr_word[cnt * 8 +: 8] = b;
            end else begin
              lng = long_form_vr(hdr_word[39:32], hdr_word[47:40]);
              // Long form: bytes 6 and 7 are reserved, 8 to 11 hold the length.
              if (lng && cnt >= 8) length_acc[(cnt - 8) * 8 +: 8] = b;
              else if (!lng && cnt < 8) length_acc[(cnt - 6) * 8 +: 8] = b;
            end
            cnt++;
            hdr_count = 4'(cnt);
            lng = long_form_vr(hdr_word[39:32], hdr_word[47:40]);
            if (cnt == int'(HDR_BASE_BYTES)) begin
              // With group, element and VR in hand, check that the rest of the header fits.
              if (lng && pos_w + 33'd7 > fl_w) begin
                recs[nrec] = make_record(RC_TRUNC_LONG, hdr_word, '0, '0);
                nrec++;
                walk_done = 1'b1;
              end else if (!lng && pos_w + 33'd3 > fl_w) begin
                recs[nrec] = make_record(RC_TRUNC_SHORT, hdr_word, '0, '0);
                nrec++;
                walk_done = 1'b1;
              end
            end else if (cnt >= (lng ? int'(HDR_LONG_END) : int'(HDR_SHORT_END))) begin
              hdr_count = '0;
              off_w = pos_w + 33'd1;
              reach = {1'b0, off_w} + {2'b00, length_acc};
              if (length_acc == UNDEF_LEN) begin
                recs[nrec] = make_record(RC_UNDEF_LENGTH, hdr_word, length_acc, off_w[31:0]);
                nrec++;
                walk_done = 1'b1;
              end else if (reach > {1'b0, fl_w}) begin
                recs[nrec] = make_record(RC_OVERRUN, hdr_word, length_acc, off_w[31:0]);
                nrec++;
                walk_done = 1'b1;
              end else begin
                recs[nrec] = make_record(RC_ELEMENT, hdr_word, length_acc, off_w[31:0]);
                nrec++;
                walk_phase = (length_acc != 0) ? PH_SKIP : PH_HEADER;
              end
            end
          end
        end
        PH_SKIP: begin
          if (length_acc != 0) length_acc = length_acc - 32'd1;
          if (length_acc == 0) begin
            walk_phase = PH_HEADER;
            hdr_count  = '0;
          end
        end
        default: ;
      endcase
      // Reaching the last byte of the file ends any walk still running.
      if (!walk_done && pos_w + 33'd1 >= fl_w) begin
        recs[nrec] = make_record(RC_DONE, '0, '0, '0);
        nrec++;
        walk_done = 1'b1;
      end
    end
    if (nrec > 0) recs[nrec - 1].last_of_run = 1'b1;
    for (int i = 0; i < nrec; i++) walk_records_due.push_back(recs[i]);
    walk_pos = walk_pos + 32'd1;
  endtask

  // ------------------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge, predicts, compares, and runs the
  // watchdog.
  // ------------------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : walk_monitor
    result_t want;
    if (rst) begin
      byte_taken   <= 1'b0;
      result_taken <= 1'b0;
    end else begin
      byte_taken   <= data_valid && data_ready;
      result_taken <= result_valid && result_ready;
      // Prediction first: a record accepted at this edge belongs to an earlier byte.
      if (data_valid && data_ready) begin
        walk_byte(data_byte);
        bytes_in++;
      end
      if (result_valid && result_ready) begin
        if (walk_records_due.size() == 0) begin
          $display("%0t: result transaction with nothing expected, actual code %0d",
                   $time, result_code);
          mismatches++;
        end else begin
          want = walk_records_due.pop_front();
          check_field("result_code", 32'(want.code), 32'(result_code));
          check_field("group_number", 32'(want.group_number), 32'(group_number));
          check_field("element_number", 32'(want.element_number), 32'(element_number));
          check_field("vr_first_char", 32'(want.vr_first_char), 32'(vr_first_char));
          check_field("vr_second_char", 32'(want.vr_second_char), 32'(vr_second_char));
          check_field("value_length", want.value_length, value_length);
          check_field("value_offset", want.value_offset, value_offset);
          check_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run));
        end
      end
      if ((data_valid && data_ready) || (result_valid && result_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
          $display("dicom_element_header_walker_tb: FAIL");
          $finish;
        end
      end
    end
  end

  // ------------------------------------------------------------------------------------
  // Byte driver: changes data_valid and data_byte at the falling edge. A byte stays on the
  // port until the monitor has seen it accepted; then the driver idles for its drawn wait
  // and takes the next byte from the queue.
  // ------------------------------------------------------------------------------------

  always @(negedge clk) begin : byte_driver
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    if (rst) begin
      data_valid <= 1'b0;
    end else begin
      nxt_valid = data_valid;
      nxt_byte  = data_byte;
      if (!data_valid || byte_taken) begin
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (file_bytes.size() > 0) begin
          nxt_byte  = file_bytes.pop_front();
          nxt_valid = 1'b1;
          // Now and then switch between paced and back-to-back sending.
          if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        end
      end
      data_valid <= nxt_valid;
      data_byte  <= nxt_byte;
    end
  end

  // ------------------------------------------------------------------------------------
  // Result receiver: draws a wait after each accepted result, and once in the run holds
  // result_ready low for a long stretch while the sender keeps going.
  // ------------------------------------------------------------------------------------

  always @(negedge clk) begin : result_receiver
    logic nxt_ready;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_taken) begin
        if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!hold_done && bytes_in >= HOLD_AT_BYTES) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      result_ready <= nxt_ready;
    end
  end

  // ------------------------------------------------------------------------------------
  // File generation
  // ------------------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] b);
    file_bytes.push_back(b);
    gen_pos = gen_pos + 32'd1;
  endtask

  task automatic push_noise(input int count);
    for (int i = 0; i < count; i++) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Little-endian element header in the form that its VR calls for. Only the low 16 bits
  // of the length go out for a short VR.
  task automatic push_header(input logic [15:0] grp, input logic [15:0] elem,
                             input logic [15:0] vr, input logic [31:0] len);
    push_byte(grp[7:0]);
    push_byte(grp[15:8]);
    push_byte(elem[7:0]);
    push_byte(elem[15:8]);
    push_byte(vr[15:8]);
    push_byte(vr[7:0]);
    if (long_form_vr(vr[15:8], vr[7:0])) begin
      push_noise(2);
      for (int i = 0; i < 4; i++) push_byte(len[i * 8 +: 8]);
    end else begin
      push_byte(len[7:0]);
      push_byte(len[15:8]);
    end
  endtask

  function automatic logic [15:0] pick_tag_half();
    case ($urandom_range(0, 15))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // A well-formed element with random tag, VR and contents; values are mostly short.
  task automatic random_element();
    int vlen;
    vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    push_header(pick_tag_half(), pick_tag_half(), pick_vr(), 32'(vlen));
    push_noise(vlen);
  endtask

  function automatic int header_bytes_for(input logic [15:0] vr);
    return long_form_vr(vr[15:8], vr[7:0]) ? int'(HDR_LONG_END) : int'(HDR_SHORT_END);
  endfunction

  // Blocks until no byte is pending and no record is owed, then lets the walker settle.
  // The check is repeated after the settling time, since the last byte may have been
  // put on the port at the very edge where the first check passed.
  task automatic wait_idle();
    do begin
      while (file_bytes.size() != 0 || data_valid || walk_records_due.size() != 0)
        @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
    end while (file_bytes.size() != 0 || data_valid || walk_records_due.size() != 0);
  endtask

  // The length register is only written with the walker idle, so our copy can change at
  // the same moment without a byte in flight.
  task automatic set_file_length(input logic [31:0] len);
    wait_idle();
    file_length_wr <= 1'b1;
    file_length    <= len;
    file_len_model = len;
    @(negedge clk);
    file_length_wr <= 1'b0;
    @(posedge clk);
  endtask

  // ------------------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------------------

  initial begin : stimulus
    walk_end_t   ending;
    logic [15:0] vr;
    int          vlen;
    int          tail;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Largest file length first, so nothing ends the walk early.
    set_file_length(32'hFFFF_FFFF);

    // Preamble with both byte extremes, then the marker.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_noise(126);
    for (int i = 3; i >= 0; i--) push_byte(MAGIC_WORD[i * 8 +: 8]);

    // Directed headers: tag extremes, every long VR with short values, zero lengths,
    // and short VRs that look like long ones.
    push_header(16'h0000, 16'h0000, short_vr_name(0), 32'd0);
    for (int i = 0; i < NUM_LONG_VRS; i++) begin
      push_header((i == 1) ? 16'hFFFF : pick_tag_half(),
                  (i == 1) ? 16'hFFFF : pick_tag_half(), long_vr_name(i), 32'(i % 3));
      push_noise(i % 3);
    end
    push_header(16'hFFFF, 16'h0000, "US", 32'd2);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_header(pick_tag_half(), pick_tag_half(), "OX", 32'd2);
    push_noise(2);
    push_header(pick_tag_half(), pick_tag_half(), "SB", 32'd1);
    push_noise(1);

    // Random elements; the long result-side hold happens in this stretch.
    while (gen_pos < PHASE_A_BYTES) random_element();

    set_file_length(32'($urandom_range(32'hFFFF_FFFE, 32'h8000_0000)));
    while (gen_pos < PHASE_B_BYTES) random_element();

    // Finish the walk one of the possible ways. Most endings set the length register to match the
    // bytes still to come, which is why the walker is drained first.
    ending = walk_end_t'($urandom_range(0, 6));
    case (ending)
      END_CLEAN, END_TRAILING: begin
        vr   = pick_vr();
        vlen = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        tail = (ending == END_TRAILING) ? $urandom_range(1, 5) : 0;
        set_file_length(gen_pos + 32'(header_bytes_for(vr) + vlen + tail));
        push_header(pick_tag_half(), pick_tag_half(), vr, 32'(vlen));
        push_noise(vlen + tail);
      end
      END_TRUNC_LONG: begin
        vr = long_vr_name($urandom_range(0, NUM_LONG_VRS - 1));
        set_file_length(gen_pos + 32'($urandom_range(6, 11)));
        push_header(pick_tag_half(), pick_tag_half(), vr, 32'd0);
      end
      END_TRUNC_SHORT: begin
        vr = short_vr_name($urandom_range(0, NUM_SHORT_VRS - 1));
        set_file_length(gen_pos + 32'($urandom_range(6, 7)));
        push_header(pick_tag_half(), pick_tag_half(), vr, 32'd0);
      end
      END_UNDEF: begin
        vr = long_vr_name($urandom_range(0, NUM_LONG_VRS - 1));
        push_header(pick_tag_half(), pick_tag_half(), vr, UNDEF_LEN);
        push_noise(4);
      end
      END_OVERRUN: begin
        vr   = pick_vr();
        vlen = $urandom_range(1, 12);
        set_file_length(gen_pos + 32'(header_bytes_for(vr) + $urandom_range(0, vlen - 1)));
        push_header(pick_tag_half(), pick_tag_half(), vr, 32'(vlen));
        push_noise(vlen);
      end
      default: begin
        // Shrinking the file below the current position ends the walk on the next byte.
        set_file_length(32'd1);
        push_noise(1);
      end
    endcase

    // The walk is over: a length of one and a few more bytes must produce nothing.
    set_file_length(32'd1);
    push_noise(NUM_IGNORED);
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && walk_records_due.size() == 0) begin
      $display("dicom_element_header_walker_tb: PASS");
    end else begin
      $display("dicom_element_header_walker_tb: FAIL");
    end
    $finish;
  end

endmodule
